// File: src/dwg_pkg.sv
// Shared types and constants for the DLA walker grid step block.
package dwg_pkg;

  localparam int DIM_BITS       = 11;
  localparam int POS_BITS       = 10;
  localparam int DIR_BITS       = 2;
  localparam int OUT_GEN_BITS   = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 40;
  localparam int GRID_RESET     = 1024;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = 1;
  localparam int QCOUNT_BITS    = 2;

  localparam logic OP_WALK = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_POS_X = 2'd0,
    DIR_NEG_X = 2'd1,
    DIR_POS_Y = 2'd2,
    DIR_NEG_Y = 2'd3
  } dir_t;

  // One classified step, as queued between front and back.
  typedef struct packed {
    logic                seed;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic [DIM_BITS-1:0] nx;
    logic [DIM_BITS-1:0] ny;
  } dwg_item_t;

endpackage

// File: src/dla_walker_grid_step.sv
// Top level of the DLA walker grid step block.
// A word taken on the input is queued; the back end then reads the neighbor cell
// in S_READ and, once the output register is free, writes the walker cell (if it
// sticks) and registers the result in S_EXEC. It handles one word at a time; the queue holds up to two more.
// Reset: synchronous; a sweep over all MAX_WIDTH*MAX_HEIGHT cells (1048576 by
// default) then clears every cell, with s_tready low; configuration writes are taken.
module dla_walker_grid_step import dwg_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int GEN_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel: index 0 grid_width, index 1 grid_height.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Step input.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // pos_x[9:0], pos_y[19:10], direction[21:20]
  input  logic                      s_tuser,   // opcode: 0 walk, 1 seed
  // Result output.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // new_x[9:0], new_y[19:10], generation[35:20]
  output logic                      m_tuser    // stuck
);

  dwg_item_t                push_item;
  dwg_item_t                head;
  logic                     push;
  logic                     pop;
  logic                     q_full;
  logic                     q_empty;
  logic                     clearing;
  logic [POS_BITS-1:0]      out_x;
  logic [POS_BITS-1:0]      out_y;
  logic [OUT_GEN_BITS-1:0]  out_gen;

  // Registers are plain flops; always accept a configuration word.
  assign cfg_ready = 1'b1;

  // Front: clamp the position to the grid in use and work out the wrapped
  // neighbor, then push the classified step into the queue.
  dwg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .in_pos_x  (s_tdata[POS_BITS-1:0]),
    .in_pos_y  (s_tdata[2*POS_BITS-1:POS_BITS]),
    .in_dir    (s_tdata[2*POS_BITS+DIR_BITS-1:2*POS_BITS]),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple the front from memory stalls and output backpressure.
  dwg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: read the neighbor cell, decide whether the walker sticks, write
  // the walker cell and hold the result until the sink takes it.
  dwg_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GEN_BITS   (GEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_stuck (m_tuser),
    .out_gen   (out_gen)
  );

  // Pack the result word; pad the top bits with zeros.
  assign m_tdata = {{(OUT_TDATA_BITS - 2*POS_BITS - OUT_GEN_BITS){1'b0}},
                    out_gen, out_y, out_x};

endmodule

// File: src/dwg_front.sv
// Front end: grid size registers, position clamp and neighbor coordinates.
module dwg_front import dwg_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [POS_BITS-1:0]       in_pos_x,
  input  logic [POS_BITS-1:0]       in_pos_y,
  input  logic [DIR_BITS-1:0]       in_dir,
  input  logic                      clearing,
  input  logic                      q_full,
  output logic                      push,
  output dwg_item_t                 push_item
);

  localparam int W_RESET = (MAX_WIDTH < GRID_RESET) ? MAX_WIDTH : GRID_RESET;
  localparam int H_RESET = (MAX_HEIGHT < GRID_RESET) ? MAX_HEIGHT : GRID_RESET;

  logic [DIM_BITS-1:0] width_eff;
  logic [DIM_BITS-1:0] height_eff;
  logic [DIM_BITS-1:0] x_ext;
  logic [DIM_BITS-1:0] y_ext;
  logic [DIM_BITS-1:0] x_cl;
  logic [DIM_BITS-1:0] y_cl;
  logic [DIM_BITS-1:0] x_inc;
  logic [DIM_BITS-1:0] y_inc;
  logic [DIM_BITS-1:0] nx;
  logic [DIM_BITS-1:0] ny;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input int maxv);
    if (v == '0) begin
      return DIM_BITS'(1);
    end else if (int'(v) > maxv) begin
      return DIM_BITS'(maxv);
    end
    return v;
  endfunction

  // Store the clamped sizes so the item path only sees legal values.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= DIM_BITS'(W_RESET);
      height_eff <= DIM_BITS'(H_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        width_eff <= clamp_dim(cfg_data, MAX_WIDTH);
      end else if (cfg_index == REG_GRID_HEIGHT) begin
        height_eff <= clamp_dim(cfg_data, MAX_HEIGHT);
      end
    end
  end

  assign x_ext = {1'b0, in_pos_x};
  assign y_ext = {1'b0, in_pos_y};
  assign x_cl  = (x_ext >= width_eff)  ? width_eff - 1'b1  : x_ext;
  assign y_cl  = (y_ext >= height_eff) ? height_eff - 1'b1 : y_ext;
  assign x_inc = x_cl + 1'b1;
  assign y_inc = y_cl + 1'b1;

  always_comb begin
    nx = x_cl;
    ny = y_cl;
    unique case (dir_t'(in_dir))
      DIR_POS_X: nx = (x_inc >= width_eff) ? '0 : x_inc;
      DIR_NEG_X: nx = (x_cl == '0) ? width_eff - 1'b1 : x_cl - 1'b1;
      DIR_POS_Y: ny = (y_inc >= height_eff) ? '0 : y_inc;
      DIR_NEG_Y: ny = (y_cl == '0) ? height_eff - 1'b1 : y_cl - 1'b1;
    endcase
  end

  assign in_ready          = !clearing && !q_full;
  assign push              = in_valid && in_ready;
  assign push_item.seed    = (in_opcode == OP_SEED);
  assign push_item.x       = x_cl[POS_BITS-1:0];
  assign push_item.y       = y_cl[POS_BITS-1:0];
  assign push_item.nx      = nx;
  assign push_item.ny      = ny;

endmodule

// File: src/dwg_queue.sv
// Two-entry queue of classified steps between front and back.
module dwg_queue import dwg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dwg_item_t push_item,
  input  logic      pop,
  output dwg_item_t head,
  output logic      full,
  output logic      empty
);

  dwg_item_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head  = entries[rd_ptr];
  assign full  = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");

endmodule

// File: src/dwg_back.sv
// Back end: cell memory, clearing sweep, stick decision and result register.
module dwg_back import dwg_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int GEN_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dwg_item_t               head,
  input  logic                    q_empty,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_BITS-1:0]     out_x,
  output logic [POS_BITS-1:0]     out_y,
  output logic                    out_stuck,
  output logic [OUT_GEN_BITS-1:0] out_gen
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_READ  = 3'b010,
    S_EXEC  = 3'b100
  } back_state_t;

  back_state_t                    state;
  back_state_t                    state_next;
  logic [GEN_BITS:0]              mem [CELLS];
  logic [GEN_BITS:0]              rd_data;
  logic [AW-1:0]                  clr_addr;
  logic [AW-1:0]                  nb_addr;
  logic [AW-1:0]                  here_addr;
  dwg_item_t                      cur;
  logic                           out_free;
  logic                           finish;
  logic                           nb_occ;
  logic [GEN_BITS-1:0]            nb_gen;
  logic [GEN_BITS-1:0]            gen_new;
  logic                           stick;
  logic [GEN_BITS+OUT_GEN_BITS-1:0] gen_ext;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [GEN_BITS:0]              mem_wdata;

  assign clearing = (state == S_CLEAR);
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_READ) && !q_empty;
  assign finish   = (state == S_EXEC) && out_free;

  assign nb_addr = AW'(head.ny) * AW'(MAX_WIDTH) + AW'(head.nx);

  assign nb_occ  = rd_data[GEN_BITS];
  assign nb_gen  = rd_data[GEN_BITS-1:0];
  assign gen_new = cur.seed ? '0 :
                   (&nb_gen) ? nb_gen : nb_gen + 1'b1;
  assign stick   = cur.seed || nb_occ;
  assign gen_ext = {{OUT_GEN_BITS{1'b0}}, gen_new};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = here_addr;
    mem_wdata = {1'b1, gen_new};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (finish && stick) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data <= mem[nb_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(CELLS - 1)) state_next = S_READ;
      S_READ:  if (pop) state_next = S_EXEC;
      S_EXEC:  if (finish) state_next = S_READ;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= head;
      here_addr <= AW'(head.y) * AW'(MAX_WIDTH) + AW'(head.x);
    end
    if (finish) begin
      out_stuck <= stick;
      out_gen   <= stick ? gen_ext[OUT_GEN_BITS-1:0] : '0;
      out_x     <= stick ? cur.x : cur.nx[POS_BITS-1:0];
      out_y     <= stick ? cur.y : cur.ny[POS_BITS-1:0];
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("queue popped during clearing sweep");
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result loaded outside execute step");
  a_free_gen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stuck) |-> (out_gen == '0))
    else $error("free walker reported nonzero generation");

endmodule

// File: sim/dla_walker_grid_step_tb.sv
// Self-checking testbench for the DLA walker grid step block.
`timescale 1ns / 1ps

module dla_walker_grid_step_tb;
  import dwg_pkg::*;

  localparam int          MAX_COLS     = 1024;
  localparam int          MAX_ROWS     = 1024;
  localparam int          LATENCY      = 2;
  // The block clears every cell after reset with s_tready low.
  localparam int          SWEEP_CYCLES = MAX_COLS * MAX_ROWS;
  localparam int          QUIET_LIMIT  = 4 * SWEEP_CYCLES;
  localparam int          REPORT_LIMIT = 10;
  localparam logic [15:0] GEN_TOP      = 16'hFFFF;
  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  // One result word, unpacked into its fields.
  typedef struct packed {
    logic [POS_BITS-1:0]     x;
    logic [POS_BITS-1:0]     y;
    logic                    stuck;
    logic [OUT_GEN_BITS-1:0] gen;
  } move_t;

  // Hand-written expectation that overrides the predictor for one word.
  typedef struct packed {
    logic  pin;
    move_t want;
  } pin_t;

  typedef struct packed {
    logic                op;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    dir_t                dir;
    pin_t                check;
  } step_row_t;

  typedef enum logic [1:0] {
    MODE_SPREAD,   // positions anywhere, mostly inside the grid
    MODE_CLUSTER,  // positions packed around a roving hub so walkers hit seeds
    MODE_CLIMB     // one seed, then walks on it so the generation keeps climbing
  } walk_mode_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] w_raw;
    logic [CFG_DATA_BITS-1:0] h_raw;
    logic [6:0]               src_pct;
    logic [6:0]               sink_pct;
    logic [16:0]              count;
    walk_mode_t               mode;
  } phase_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
  logic                      s_tuser   = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tuser;

  // Shadow of the block: raw register values and the occupied cells.
  // A cell is occupied exactly when it has an entry in cell_gen.
  logic [CFG_DATA_BITS-1:0]  width_raw  = CFG_DATA_BITS'(GRID_RESET);
  logic [CFG_DATA_BITS-1:0]  height_raw = CFG_DATA_BITS'(GRID_RESET);
  logic [OUT_GEN_BITS-1:0]   cell_gen [int unsigned];

  move_t       pending_moves [$];
  pin_t        pinned_moves [$];
  int          move_errors    = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  // Directed part at the reset grid of 1024 x 1024. Pinned rows carry the
  // expected word; the rest go through the predictor.
  step_row_t opening_steps [21] = '{
    // wrap on every edge, empty grid
    '{OP_WALK, 10'd0,    10'd0,    DIR_NEG_X, '{1'b1, '{10'd1023, 10'd0,    1'b0, 16'd0}}},
    '{OP_WALK, 10'd1023, 10'd0,    DIR_POS_X, '{1'b1, '{10'd0,    10'd0,    1'b0, 16'd0}}},
    '{OP_WALK, 10'd0,    10'd0,    DIR_NEG_Y, '{1'b1, '{10'd0,    10'd1023, 1'b0, 16'd0}}},
    '{OP_WALK, 10'd0,    10'd1023, DIR_POS_Y, '{1'b1, '{10'd0,    10'd0,    1'b0, 16'd0}}},
    '{OP_WALK, 10'd1023, 10'd1023, DIR_POS_Y, '{1'b1, '{10'd1023, 10'd0,    1'b0, 16'd0}}},
    '{OP_WALK, 10'd1023, 10'd1023, DIR_NEG_X, '{1'b1, '{10'd1022, 10'd1023, 1'b0, 16'd0}}},
    // seed at the corner, direction is ignored
    '{OP_SEED, 10'd0,    10'd0,    DIR_NEG_Y, '{1'b1, '{10'd0,    10'd0,    1'b1, 16'd0}}},
    // grow a short chain along row 0
    '{OP_WALK, 10'd1,    10'd0,    DIR_NEG_X, '{1'b1, '{10'd1,    10'd0,    1'b1, 16'd1}}},
    '{OP_WALK, 10'd2,    10'd0,    DIR_NEG_X, '{1'b1, '{10'd2,    10'd0,    1'b1, 16'd2}}},
    // stick across the wrap in both axes
    '{OP_WALK, 10'd1023, 10'd0,    DIR_POS_X, '{1'b1, '{10'd1023, 10'd0,    1'b1, 16'd1}}},
    '{OP_WALK, 10'd0,    10'd1,    DIR_NEG_Y, '{1'b1, '{10'd0,    10'd1,    1'b1, 16'd1}}},
    '{OP_WALK, 10'd0,    10'd1023, DIR_POS_Y, '{1'b1, '{10'd0,    10'd1023, 1'b1, 16'd1}}},
    // seed over an occupied cell drops its generation back to zero
    '{OP_SEED, 10'd2,    10'd0,    DIR_POS_X, '{1'b1, '{10'd2,    10'd0,    1'b1, 16'd0}}},
    '{OP_WALK, 10'd3,    10'd0,    DIR_NEG_X, '{1'b1, '{10'd3,    10'd0,    1'b1, 16'd1}}},
    // walker standing on an occupied cell: only the neighbor matters
    '{OP_WALK, 10'd2,    10'd0,    DIR_POS_X, '{1'b1, '{10'd2,    10'd0,    1'b1, 16'd2}}},
    '{OP_WALK, 10'd2,    10'd0,    DIR_POS_Y, '{1'b1, '{10'd2,    10'd1,    1'b0, 16'd0}}},
    '{OP_SEED, 10'd1023, 10'd1023, DIR_NEG_X, '{1'b1, '{10'd1023, 10'd1023, 1'b1, 16'd0}}},
    '{OP_WALK, 10'd1022, 10'd1023, DIR_POS_X, '{1'b1, '{10'd1022, 10'd1023, 1'b1, 16'd1}}},
    '{OP_WALK, 10'd682,  10'd341,  DIR_NEG_X, '0},
    '{OP_SEED, 10'd341,  10'd682,  DIR_POS_Y, '0},
    '{OP_WALK, 10'd341,  10'd683,  DIR_NEG_Y, '0}
  };

  // Random phases: grid setting, idling, length and style of stimulus.
  phase_t plan [8] = '{
    '{11'd8,    11'd8,    7'd0,  7'd0,  17'd270,   MODE_SPREAD},
    '{11'd0,    11'd16,   7'd77, 7'd0,  17'd200,   MODE_SPREAD},
    '{11'd16,   11'd1,    7'd0,  7'd77, 17'd200,   MODE_SPREAD},
    '{11'd2047, 11'd1025, 7'd21, 7'd21, 17'd350,   MODE_CLUSTER},
    '{11'd1024, 11'd1024, 7'd0,  7'd77, 17'd250,   MODE_CLUSTER},
    '{11'd5,    11'd3,    7'd77, 7'd0,  17'd200,   MODE_SPREAD},
    '{11'd37,   11'd2,    7'd21, 7'd21, 17'd150,   MODE_SPREAD},
    '{11'd1,    11'd1,    7'd0,  7'd0,  17'd30,    MODE_CLIMB}
  };

  dla_walker_grid_step #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS),
    .GEN_BITS  (OUT_GEN_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Out-of-range register values: zero acts as one, too large as the maximum.
  function automatic int unsigned fit_dim(logic [CFG_DATA_BITS-1:0] raw, int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // Work out the word one step produces and update the shadow grid.
  function automatic move_t predict_walker_step(logic op, logic [POS_BITS-1:0] px,
                                                logic [POS_BITS-1:0] py, dir_t d);
    int unsigned             w, h, x, y, nx, ny, here, nb;
    logic [OUT_GEN_BITS-1:0] g;
    move_t                   r;
    w = fit_dim(width_raw, MAX_COLS);
    h = fit_dim(height_raw, MAX_ROWS);
    // Clamp positions that lie outside the used grid to its last column/row.
    x = (px >= w) ? w - 1 : px;
    y = (py >= h) ? h - 1 : py;
    here = y * MAX_COLS + x;
    r = '0;
    r.x = POS_BITS'(x);
    r.y = POS_BITS'(y);
    if (op == OP_SEED) begin
      cell_gen[here] = '0;
      r.stuck = 1'b1;
    end else begin
      nx = x;
      ny = y;
      case (d)
        DIR_POS_X: nx = (x + 1 >= w) ? 0 : x + 1;
        DIR_NEG_X: nx = (x == 0) ? w - 1 : x - 1;
        DIR_POS_Y: ny = (y + 1 >= h) ? 0 : y + 1;
        default:   ny = (y == 0) ? h - 1 : y - 1;
      endcase
      nb = ny * MAX_COLS + nx;
      if (cell_gen.exists(nb)) begin
        // Stick here; the generation saturates at the top of its range.
        g = (cell_gen[nb] == GEN_TOP) ? GEN_TOP : cell_gen[nb] + 1'b1;
        cell_gen[here] = g;
        r.stuck = 1'b1;
        r.gen = g;
      end else begin
        r.x = POS_BITS'(nx);
        r.y = POS_BITS'(ny);
      end
    end
    return r;
  endfunction

  // Present one step word; return at the edge that takes it, valid still high.
  task automatic send_step(logic op, logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y,
                           dir_t d, pin_t check);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    pinned_moves.insert(pinned_moves.size(), check);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, d, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after the last write.
  task automatic set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  width_raw = val;
      REG_GRID_HEIGHT: height_raw = val;
      default: ;
    endcase
  endtask

  // Drop valid, then hold until every pending word is out and the pipe is quiet.
  task automatic settle_moves();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Predict each accepted step word, or take its pinned expectation.
  always @(posedge clk) begin
    pin_t  check;
    move_t want;
    if (!rst && s_tvalid && s_tready) begin
      check = pinned_moves.pop_front();
      want = predict_walker_step(s_tuser, s_tdata[9:0], s_tdata[19:10],
                                 dir_t'(s_tdata[21:20]));
      pending_moves.insert(pending_moves.size(), check.pin ? check.want : want);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    move_t got;
    move_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.x     = m_tdata[9:0];
      got.y     = m_tdata[19:10];
      got.gen   = m_tdata[35:20];
      got.stuck = m_tuser;
      if (pending_moves.size() == 0) begin
        move_errors++;
        if (move_errors <= REPORT_LIMIT)
          $display("ERROR %0t: unexpected word x=%0d y=%0d stuck=%0d gen=%0d",
                   $realtime, got.x, got.y, got.stuck, got.gen);
      end else begin
        want = pending_moves.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.stuck !== want.stuck ||
            got.gen !== want.gen) begin
          move_errors++;
          if (move_errors <= REPORT_LIMIT)
            $display("ERROR %0t: expected x,y,stuck,gen=%0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
                     $realtime, want.x, want.y, want.stuck, want.gen,
                     got.x, got.y, got.stuck, got.gen);
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  // The limit covers the clearing sweep after reset.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned         w_fit, h_fit;
    logic                op;
    logic [POS_BITS-1:0] x, y, hub_x, hub_y;
    dir_t                d;

    hub_x = '0;
    hub_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset grid, no idling.
    foreach (opening_steps[i])
      send_step(opening_steps[i].op, opening_steps[i].x, opening_steps[i].y,
                opening_steps[i].dir, opening_steps[i].check);
    settle_moves();

    foreach (plan[p]) begin
      // Reprogram the grid while the block is idle; spare indexes must be ignored.
      set_reg(REG_GRID_WIDTH, plan[p].w_raw);
      set_reg(REG_GRID_HEIGHT, plan[p].h_raw);
      set_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
      set_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom));
      cfg_valid <= 1'b0;
      src_idle_pct   = plan[p].src_pct;
      sink_stall_pct = plan[p].sink_pct;
      w_fit = fit_dim(width_raw, MAX_COLS);
      h_fit = fit_dim(height_raw, MAX_ROWS);

      for (int i = 0; i < plan[p].count; i++) begin
        d = dir_t'($urandom_range(3));
        case (plan[p].mode)
          MODE_SPREAD: begin
            // Mostly inside the grid; the rest exercises position clamping.
            op = ($urandom_range(99) < 12) ? OP_SEED : OP_WALK;
            x = ($urandom_range(99) < 85) ? POS_BITS'($urandom_range(w_fit - 1))
                                          : POS_BITS'($urandom_range(1023));
            y = ($urandom_range(99) < 85) ? POS_BITS'($urandom_range(h_fit - 1))
                                          : POS_BITS'($urandom_range(1023));
          end
          MODE_CLUSTER: begin
            // Move the hub now and then so every position bit toggles.
            if (i % 40 == 0) begin
              hub_x = POS_BITS'($urandom);
              hub_y = POS_BITS'($urandom);
            end
            op = ($urandom_range(99) < 20) ? OP_SEED : OP_WALK;
            x = hub_x + POS_BITS'($urandom_range(7));
            y = hub_y + POS_BITS'($urandom_range(7));
          end
          default: begin
            // Single cell grid: every walk sticks to itself and the generation climbs.
            op = (i == 0) ? OP_SEED : OP_WALK;
            x = POS_BITS'($urandom);
            y = POS_BITS'($urandom);
          end
        endcase
        send_step(op, x, y, d, '0);
      end
      settle_moves();
    end

    if (move_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
